// ----- hdl/wwpjw_pkg.sv -----
`default_nettype none

package wwpjw_pkg;

   // field widths fixed by the interface
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned LENGTH_W = 16;
   localparam int unsigned BUCKET_W = 12;
   localparam int unsigned TAG_W    = 13;

   // pjw fold constants
   localparam logic [WORD_W-1:0] TOP_KEEP   = 32'h00ff_ffff;
   localparam int unsigned       STEP_SHIFT = 4;
   localparam int unsigned       TOP_SHIFT  = 20;
   localparam int unsigned       MIX_SHIFT  = 6;

   // number of bytes in a full word
   localparam int unsigned WORD_BYTES = 4;

   typedef struct packed {
      logic                start_req;
      logic [LENGTH_W-1:0] name_length;
      logic [WORD_W-1:0]   word;
   } item_type;

   typedef struct packed {
      logic                emit;
      logic [BUCKET_W-1:0] bucket;
      logic [TAG_W-1:0]    tag;
   } result_type;

   // one pjw update: shift, add, fold the top byte back in
   function automatic logic [WORD_W-1:0] pjw_step(input logic [WORD_W-1:0] h,
                                                  input logic [WORD_W-1:0] x);
      logic [WORD_W-1:0] s;
      logic [WORD_W-1:0] g;
      s = (h << STEP_SHIFT) + x;
      g = s & ~TOP_KEEP;
      s = s ^ g;
      s = s ^ (g >> TOP_SHIFT);
      return s;
   endfunction

   // fold to 12 bits then mix; the top byte is already clear after pjw_step
   function automatic logic [BUCKET_W-1:0] bucket_mix(input logic [WORD_W-1:0] h);
      logic [BUCKET_W-1:0] f;
      f = h[BUCKET_W-1:0] ^ h[2*BUCKET_W-1:BUCKET_W];
      return f ^ (f >> MIX_SHIFT);
   endfunction

   // keep the valid low bytes of the last word
   function automatic logic [WORD_W-1:0] byte_mask(input logic [2:0] n);
      logic [WORD_W-1:0] m;
      case (n)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/wwpjw_inreg.sv -----
`default_nettype none

module wwpjw_inreg
   import wwpjw_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire item_type req_item,
   input  wire logic     take,
   output logic          item_valid,
   output item_type      item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   // register is free when empty or its item moves on this cycle
   assign req_stall = valid_ff && !take;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ----- hdl/wwpjw_hash.sv -----
`default_nettype none

module wwpjw_hash
   import wwpjw_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 16
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     item_valid,
   input  wire item_type item,
   input  wire logic     out_free,
   output logic          take,
   output result_type    result
);

   // the length port is 16 bits, so never keep more than that
   localparam int unsigned LEN_W = (LENGTH_BITS < LENGTH_W) ? LENGTH_BITS : LENGTH_W;

   logic [WORD_W-1:0] hash_ff, hash_in;
   logic [WORD_W-1:0] xor_ff, xor_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [7:0]        low_ff, low_in;

   logic [LEN_W-1:0]  len;
   logic [WORD_W-1:0] seed_hash;
   logic [WORD_W-1:0] seed_xor;
   logic [LEN_W-1:0]  seed_left;
   logic [7:0]        seed_low;
   logic              active;
   logic              full_word;
   logic              emit;
   logic [WORD_W-1:0] xor_next;
   logic [WORD_W-1:0] pjw_next;
   logic [BUCKET_W-1:0] bucket;

   // seed from the length on a start transfer
   assign len       = item.name_length[LEN_W-1:0];
   assign seed_hash = item.start_req ? WORD_W'(len) : hash_ff;
   assign seed_xor  = item.start_req ? WORD_W'(len) : xor_ff;
   assign seed_left = item.start_req ? len : left_ff;
   assign seed_low  = item.start_req ? len[7:0] : low_ff;

   // words with no name in progress are dropped
   assign active    = item.start_req || (left_ff != '0);
   assign full_word = seed_left > LEN_W'(WORD_BYTES);
   assign emit      = active && !full_word;

   // word update and final bucket
   assign xor_next = seed_xor ^ (full_word ? item.word
                                           : (item.word & byte_mask(seed_left[2:0])));
   assign pjw_next = pjw_step(seed_hash, xor_next);
   assign bucket   = bucket_mix(pjw_next);

   // a finishing item waits for room in the result register
   assign take = item_valid && (!emit || out_free);

   always_comb begin
      hash_in = hash_ff;
      xor_in  = xor_ff;
      left_in = left_ff;
      low_in  = low_ff;
      if (take && active) begin
         xor_in = xor_next;
         low_in = seed_low;
         if (full_word) begin
            hash_in = pjw_next;
            left_in = seed_left - LEN_W'(WORD_BYTES);
         end else begin
            hash_in = WORD_W'(bucket);
            left_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= '0;
         xor_ff  <= '0;
         left_ff <= '0;
         low_ff  <= '0;
      end else begin
         hash_ff <= hash_in;
         xor_ff  <= xor_in;
         left_ff <= left_in;
         low_ff  <= low_in;
      end
   end

   assign result.emit   = take && emit;
   assign result.bucket = bucket;
   assign result.tag    = TAG_W'(bucket) + TAG_W'(seed_low);

endmodule

`default_nettype wire

// ----- hdl/wwpjw_outreg.sv -----
`default_nettype none

module wwpjw_outreg
   import wwpjw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire result_type result,
   output logic            out_free,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [BUCKET_W-1:0] rsp_bucket,
   output logic [TAG_W-1:0]    rsp_tag
);

   logic                valid_ff;
   logic                valid_in;
   logic [BUCKET_W-1:0] bucket_ff;
   logic [TAG_W-1:0]    tag_ff;

   // room when empty or the waiting result leaves this cycle
   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (result.emit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.emit) begin
         bucket_ff <= result.bucket;
         tag_ff    <= result.tag;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_bucket = bucket_ff;
   assign rsp_tag    = tag_ff;

endmodule

`default_nettype wire

// ----- hdl/wordwise_pjw_name_hash.sv -----
// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | req_start_req, req_name_length, req_word
// rsp     | out       | rsp_valid, rsp_stall | rsp_bucket, rsp_tag
//
// one word per cycle, except while a finished result waits under rsp_stall; the hash
// state and the result register both load when the input register's word is taken,
// so a bucket appears in the cycle after the last word of a name is taken
// the combinational pjw update on the running hash sets the rate
// reset clears the running state and both valid flags
// a waiting result under rsp_stall holds back only the word that ends a name;
// other words keep flowing
`default_nettype none

module wordwise_pjw_name_hash
   import wwpjw_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_start_req,
   input  wire logic [LENGTH_W-1:0] req_name_length,
   input  wire logic [WORD_W-1:0]   req_word,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [BUCKET_W-1:0]      rsp_bucket,
   output logic [TAG_W-1:0]         rsp_tag
);

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       take;
   logic       out_free;
   result_type result;

   assign req_item.start_req   = req_start_req;
   assign req_item.name_length = req_name_length;
   assign req_item.word        = req_word;

   // input register
   wwpjw_inreg u_inreg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // running hash and final mix
   wwpjw_hash #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_hash (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .result     (result)
   );

   // result register
   wwpjw_outreg u_outreg (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_bucket (rsp_bucket),
      .rsp_tag    (rsp_tag)
   );

   // a finished bucket is never written over a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      result.emit |-> out_free)
      else $error("result written while result register blocked");

   // input only stalls while its register holds a word
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid)
      else $error("input stalled with empty register");

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // tag is bucket plus a byte, so never below the bucket
   a_tag_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tag >= TAG_W'(rsp_bucket)))
      else $error("tag below bucket");

endmodule

`default_nettype wire
